// ----- rtl/bra_pkg.sv -----
package bra_pkg;

  // Default sizing
  localparam int DEF_MAX_PROCESSES = 8;
  localparam int DEF_MAX_RESOURCES = 4;
  localparam int DEF_COUNT_BITS    = 8;

  // Port field widths
  localparam int CMD_W      = 3;
  localparam int PIDX_W     = 3;
  localparam int RIDX_W     = 2;
  localparam int AMT_W      = 8;
  localparam int PCNT_W     = 4;
  localparam int RCNT_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_LOAD_ALLOC = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_MAX   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_AVAIL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STAGE_REQ  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SUBMIT     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CHECK      = 3'd5;

  // Config register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESOURCE_COUNT = 1'b1;
  localparam logic [PCNT_W-1:0]    PCNT_RESET = 4'd8;
  localparam logic [RCNT_W-1:0]    RCNT_RESET = 3'd4;

  // Result kinds
  localparam logic KIND_ENTRY   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Controller -> datapath commands
  typedef struct packed {
    logic ld_alloc;
    logic ld_max;
    logic ld_avail;
    logic ld_req;
    logic sub_start;
    logic chk_start;
    logic row_start;
    logic ev_sub;
    logic ev_chk;
    logic grant_apply;
    logic wr_step;
    logic commit;
    logic p_next;
    logic pass_restart;
    logic emit_sub;
    logic emit_chk;
  } bra_ctl_t;

  // Datapath -> controller status
  typedef struct packed {
    logic ok;
    logic nr_zero;
    logic r_last;
    logic p_in_range;
    logic p_finished;
    logic progress;
    logic out_free;
  } bra_stat_t;

endpackage

// ----- rtl/bra_ram.sv -----
module bra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/bra_ctrl.sv -----
module bra_ctrl
  import bra_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMD_W-1:0] in_command,
  input  bra_stat_t        st,
  output bra_ctl_t         ctl
);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_S_RD   = 12'b0000_0000_0010,
    ST_S_EV   = 12'b0000_0000_0100,
    ST_S_DEC  = 12'b0000_0000_1000,
    ST_S_WR   = 12'b0000_0001_0000,
    ST_S_OUT  = 12'b0000_0010_0000,
    ST_C_SCAN = 12'b0000_0100_0000,
    ST_C_RD   = 12'b0000_1000_0000,
    ST_C_EV   = 12'b0001_0000_0000,
    ST_C_DEC  = 12'b0010_0000_0000,
    ST_C_EMIT = 12'b0100_0000_0000,
    ST_C_FIN  = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_command)
            CMD_LOAD_ALLOC: ctl.ld_alloc = 1'b1;
            CMD_LOAD_MAX:   ctl.ld_max   = 1'b1;
            CMD_LOAD_AVAIL: ctl.ld_avail = 1'b1;
            CMD_STAGE_REQ:  ctl.ld_req   = 1'b1;
            CMD_SUBMIT: begin
              ctl.sub_start = 1'b1;
              state_nxt     = ST_S_RD;
            end
            CMD_CHECK: begin
              ctl.chk_start = 1'b1;
              state_nxt     = ST_C_SCAN;
            end
            default: ;
          endcase
        end
      end
      // submit: read, then evaluate each element; stop early on a miss
      ST_S_RD: begin
        if (!st.ok || st.nr_zero) begin
          state_nxt = ST_S_DEC;
        end else begin
          state_nxt = ST_S_EV;
        end
      end
      ST_S_EV: begin
        ctl.ev_sub = 1'b1;
        state_nxt  = st.r_last ? ST_S_DEC : ST_S_RD;
      end
      ST_S_DEC: begin
        if (st.ok) begin
          ctl.grant_apply = 1'b1;
          state_nxt       = st.nr_zero ? ST_S_OUT : ST_S_WR;
        end else begin
          state_nxt = ST_S_OUT;
        end
      end
      ST_S_WR: begin
        ctl.wr_step = 1'b1;
        if (st.r_last) begin
          state_nxt = ST_S_OUT;
        end
      end
      ST_S_OUT: begin
        if (st.out_free) begin
          ctl.emit_sub = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      // safety check: passes over the processes until one makes no progress
      ST_C_SCAN: begin
        if (!st.p_in_range) begin
          if (st.progress) begin
            ctl.pass_restart = 1'b1;
          end else begin
            state_nxt = ST_C_FIN;
          end
        end else if (st.p_finished) begin
          ctl.p_next = 1'b1;
        end else begin
          ctl.row_start = 1'b1;
          state_nxt     = st.nr_zero ? ST_C_DEC : ST_C_RD;
        end
      end
      ST_C_RD: begin
        state_nxt = st.ok ? ST_C_EV : ST_C_DEC;
      end
      ST_C_EV: begin
        ctl.ev_chk = 1'b1;
        state_nxt  = st.r_last ? ST_C_DEC : ST_C_RD;
      end
      ST_C_DEC: begin
        if (st.ok) begin
          state_nxt = ST_C_EMIT;
        end else begin
          ctl.p_next = 1'b1;
          state_nxt  = ST_C_SCAN;
        end
      end
      ST_C_EMIT: begin
        if (st.out_free) begin
          ctl.commit = 1'b1;
          state_nxt  = ST_C_SCAN;
        end
      end
      ST_C_FIN: begin
        if (st.out_free) begin
          ctl.emit_chk = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/bra_dp.sv -----
module bra_dp
  import bra_pkg::*;
#(
  parameter int MAX_PROCESSES = DEF_MAX_PROCESSES,
  parameter int MAX_RESOURCES = DEF_MAX_RESOURCES,
  parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bra_ctl_t              ctl,
  output bra_stat_t             st,
  input  logic [PIDX_W-1:0]     in_process_index,
  input  logic [RIDX_W-1:0]     in_resource_index,
  input  logic [AMT_W-1:0]      in_amount,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_result_kind,
  output logic [PIDX_W-1:0]     out_result_process,
  output logic                  out_ok,
  output logic                  out_last
);

  localparam int PW    = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int RW    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int NPW   = $clog2(MAX_PROCESSES + 1);
  localparam int NRW   = $clog2(MAX_RESOURCES + 1);
  localparam int WW    = COUNT_BITS + 4;
  localparam int AW    = PW + RW;
  localparam int DEPTH = 1 << AW;

  // config
  logic [PCNT_W-1:0] proc_cnt_r;
  logic [RCNT_W-1:0] res_cnt_r;
  logic [NPW-1:0]    np;
  logic [NRW-1:0]    nr;

  // small state
  logic [COUNT_BITS-1:0] avail_r     [MAX_RESOURCES];
  logic [COUNT_BITS-1:0] req_r       [MAX_RESOURCES];
  logic [WW-1:0]         work_r      [MAX_RESOURCES];
  logic [COUNT_BITS-1:0] alloc_buf_r [MAX_RESOURCES];
  logic [MAX_PROCESSES-1:0] fin_r;
  logic [NPW-1:0]        p_cnt_r;
  logic [NPW-1:0]        done_r;
  logic [RW-1:0]         r_cnt_r;
  logic                  ok_r;
  logic                  progress_r;
  logic [PIDX_W-1:0]     sub_p_r;

  // tables
  logic [DEPTH-1:0]      alloc_vld_r, max_vld_r;
  logic                  alloc_rv_r, max_rv_r;
  logic                  alloc_we, max_we;
  logic [AW-1:0]         alloc_waddr, ld_addr, rd_addr;
  logic [COUNT_BITS-1:0] alloc_wdata, alloc_q, max_q, alloc_rd, max_rd;

  logic [COUNT_BITS-1:0] amt;
  logic                  p_in_ok, r_in_ok;
  logic [RW-1:0]         r_in;
  logic signed [COUNT_BITS:0]   need;
  logic signed [COUNT_BITS+4:0] need_x, work_x;
  logic                  sub_miss, chk_miss;

  // output register
  logic              out_valid_r;
  logic              kind_r, res_ok_r, last_r;
  logic [PIDX_W-1:0] res_p_r;
  logic              out_free;

  assign np = (32'(proc_cnt_r) > MAX_PROCESSES) ? NPW'(MAX_PROCESSES) : NPW'(proc_cnt_r);
  assign nr = (32'(res_cnt_r) > MAX_RESOURCES) ? NRW'(MAX_RESOURCES) : NRW'(res_cnt_r);

  assign amt     = COUNT_BITS'(in_amount);
  assign p_in_ok = 32'(in_process_index) < MAX_PROCESSES;
  assign r_in_ok = 32'(in_resource_index) < MAX_RESOURCES;
  assign r_in    = RW'(in_resource_index);
  assign ld_addr = {PW'(in_process_index), r_in};
  assign rd_addr = {p_cnt_r[PW-1:0], r_cnt_r};

  // table write ports
  assign alloc_we    = (ctl.ld_alloc && p_in_ok && r_in_ok) || ctl.wr_step;
  assign alloc_waddr = ctl.wr_step ? rd_addr : ld_addr;
  assign alloc_wdata = ctl.wr_step ? (alloc_buf_r[r_cnt_r] + req_r[r_cnt_r]) : amt;
  assign max_we      = ctl.ld_max && p_in_ok && r_in_ok;

  bra_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_alloc_ram (
    .clk   (clk),
    .we    (alloc_we),
    .waddr (alloc_waddr),
    .wdata (alloc_wdata),
    .raddr (rd_addr),
    .rdata (alloc_q)
  );

  bra_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_max_ram (
    .clk   (clk),
    .we    (max_we),
    .waddr (ld_addr),
    .wdata (amt),
    .raddr (rd_addr),
    .rdata (max_q)
  );

  // never-written entries read as zero
  assign alloc_rd = alloc_rv_r ? alloc_q : '0;
  assign max_rd   = max_rv_r   ? max_q   : '0;

  // need = max - alloc, signed
  assign need     = $signed({1'b0, max_rd}) - $signed({1'b0, alloc_rd});
  assign need_x   = {{4{need[COUNT_BITS]}}, need};
  assign work_x   = $signed({1'b0, work_r[r_cnt_r]});
  assign sub_miss = ($signed({1'b0, req_r[r_cnt_r]}) > need) ||
                    (req_r[r_cnt_r] > avail_r[r_cnt_r]);
  assign chk_miss = need_x > work_x;

  assign out_free = !out_valid_r || !out_stall;

  assign st.ok         = ok_r;
  assign st.nr_zero    = (nr == '0);
  assign st.r_last     = (NRW'(r_cnt_r) + NRW'(1)) == nr;
  assign st.p_in_range = p_cnt_r < np;
  assign st.p_finished = fin_r[p_cnt_r[PW-1:0]];
  assign st.progress   = progress_r;
  assign st.out_free   = out_free;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_cnt_r  <= PCNT_RESET;
      res_cnt_r   <= RCNT_RESET;
      alloc_vld_r <= '0;
      max_vld_r   <= '0;
      fin_r       <= '0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < MAX_RESOURCES; r++) begin
        avail_r[r] <= '0;
        req_r[r]   <= '0;
        work_r[r]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PROCESS_COUNT:  proc_cnt_r <= cfg_wdata[PCNT_W-1:0];
          CFG_RESOURCE_COUNT: res_cnt_r  <= cfg_wdata[RCNT_W-1:0];
          default: ;
        endcase
      end
      if (alloc_we) begin
        alloc_vld_r[alloc_waddr] <= 1'b1;
      end
      if (max_we) begin
        max_vld_r[ld_addr] <= 1'b1;
      end
      if (ctl.ld_avail && r_in_ok) begin
        avail_r[r_in] <= amt;
      end
      if (ctl.ld_req && r_in_ok) begin
        req_r[r_in] <= amt;
      end
      if (ctl.grant_apply) begin
        for (int r = 0; r < MAX_RESOURCES; r++) begin
          if (NRW'(r) < nr) begin
            avail_r[r] <= avail_r[r] - req_r[r];
          end
        end
      end
      if (ctl.chk_start) begin
        fin_r <= '0;
        for (int r = 0; r < MAX_RESOURCES; r++) begin
          work_r[r] <= (NRW'(r) < nr) ? WW'(avail_r[r]) : '0;
        end
      end
      if (ctl.commit) begin
        fin_r[p_cnt_r[PW-1:0]] <= 1'b1;
        for (int r = 0; r < MAX_RESOURCES; r++) begin
          if (NRW'(r) < nr) begin
            // saturating add into the work vector
            logic [WW:0] sum;
            sum = {1'b0, work_r[r]} + (WW+1)'(alloc_buf_r[r]);
            work_r[r] <= sum[WW] ? {WW{1'b1}} : sum[WW-1:0];
          end
        end
      end
      if (ctl.commit || ctl.emit_sub || ctl.emit_chk) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // sequencing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_cnt_r    <= '0;
      r_cnt_r    <= '0;
      done_r     <= '0;
      ok_r       <= 1'b0;
      progress_r <= 1'b0;
    end else begin
      if (ctl.sub_start || ctl.row_start || ctl.grant_apply) begin
        r_cnt_r <= '0;
      end else if (ctl.ev_sub || ctl.ev_chk || ctl.wr_step) begin
        r_cnt_r <= r_cnt_r + RW'(1);
      end

      if (ctl.sub_start) begin
        ok_r <= 32'(in_process_index) < 32'(np);
      end else if (ctl.row_start) begin
        ok_r <= 1'b1;
      end else if (ctl.ev_sub) begin
        ok_r <= ok_r && !sub_miss;
      end else if (ctl.ev_chk) begin
        ok_r <= ok_r && !chk_miss;
      end

      if (ctl.sub_start) begin
        p_cnt_r <= NPW'(in_process_index);
      end else if (ctl.chk_start || ctl.pass_restart) begin
        p_cnt_r <= '0;
      end else if (ctl.p_next || ctl.commit) begin
        p_cnt_r <= p_cnt_r + NPW'(1);
      end

      if (ctl.chk_start || ctl.pass_restart) begin
        progress_r <= 1'b0;
      end else if (ctl.commit) begin
        progress_r <= 1'b1;
      end

      if (ctl.chk_start) begin
        done_r <= '0;
      end else if (ctl.commit) begin
        done_r <= done_r + NPW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    alloc_rv_r <= alloc_vld_r[rd_addr];
    max_rv_r   <= max_vld_r[rd_addr];
    if (ctl.sub_start) begin
      sub_p_r <= in_process_index;
    end
    if (ctl.ev_sub || ctl.ev_chk) begin
      alloc_buf_r[r_cnt_r] <= alloc_rd;
    end
    if (ctl.commit) begin
      kind_r   <= KIND_ENTRY;
      res_p_r  <= PIDX_W'(p_cnt_r);
      res_ok_r <= 1'b0;
      last_r   <= 1'b0;
    end else if (ctl.emit_sub) begin
      kind_r   <= KIND_VERDICT;
      res_p_r  <= sub_p_r;
      res_ok_r <= ok_r;
      last_r   <= 1'b1;
    end else if (ctl.emit_chk) begin
      kind_r   <= KIND_VERDICT;
      res_p_r  <= '0;
      res_ok_r <= (done_r == np);
      last_r   <= 1'b1;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = kind_r;
  assign out_result_process = res_p_r;
  assign out_ok             = res_ok_r;
  assign out_last           = last_r;

endmodule

// ----- rtl/bankers_resource_allocator_top.sv -----
// Banker's-algorithm deadlock-avoidance unit.
// Input channel (in_valid / in_stall): one request per handshake carrying
//   command, process_index, resource_index and amount. Loads of allocation,
//   maximum, available and staged-request entries give no result. A submit
//   gives one verdict (kind 1, last 1). A check gives one
//   sequence entry per process found safe, then a verdict marked last.
// Output channel (out_valid / out_stall): one registered result slot. While a
//   result waits, the unit keeps working and takes further loads; a submit or
//   check stalls only where it must place a result into the occupied slot.
// Timing: the allocation and maximum tables sit in RAMs with a registered
//   read port, so each resource element takes a read step, then a compare.
//   Submit adds a write-back step per resource on a grant.
//   Check: passes over the processes repeat until one finds nothing.
// Reset (rst_n low, synchronous): counts go to 8 processes / 4 resources,
//   vectors clear and per-entry valid bits make every table read zero. No
//   clearing pass: the unit takes requests as soon as rst_n goes high.
// Config (cfg_we/cfg_index/cfg_wdata): the user writes it only while the unit is idle; the block does not enforce it.
module bankers_resource_allocator_top
  import bra_pkg::*;
#(
  parameter int MAX_PROCESSES = DEF_MAX_PROCESSES,
  parameter int MAX_RESOURCES = DEF_MAX_RESOURCES,
  parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [PIDX_W-1:0]     in_process_index,
  input  logic [RIDX_W-1:0]     in_resource_index,
  input  logic [AMT_W-1:0]      in_amount,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_result_kind,
  output logic [PIDX_W-1:0]     out_result_process,
  output logic                  out_ok,
  output logic                  out_last,
  // config write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  bra_ctl_t  ctl;
  bra_stat_t st;

  // sequencer: decodes requests, walks submit and check
  bra_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .st         (st),
    .ctl        (ctl)
  );

  // tables, vectors, comparators and the result register
  bra_dp #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .MAX_RESOURCES (MAX_RESOURCES),
    .COUNT_BITS    (COUNT_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .st                 (st),
    .in_process_index   (in_process_index),
    .in_resource_index  (in_resource_index),
    .in_amount          (in_amount),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_result_process (out_result_process),
    .out_ok             (out_ok),
    .out_last           (out_last)
  );

endmodule
